>>> rtl/arat_pkg.sv
package arat_pkg;

  localparam int unsigned TableEntriesDef = 128;
  localparam int unsigned AddrBitsDef     = 64;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned BaseW   = 64;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 7;
  localparam int unsigned OffW    = 32;

  typedef enum logic [ModeW-1:0] {
    ModeAdd    = 2'd0,
    ModeMark   = 2'd1,
    ModeLookup = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk   = 2'd0,
    StatusFull = 2'd1,
    StatusMiss = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StScan = 2'd1,
    StDone = 2'd2
  } state_e;

endpackage

>>> rtl/arat_req_if.sv
interface arat_req_if import arat_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [BaseW-1:0] base_address;
  logic [SizeW-1:0] region_size;
  logic             build_dirty;
  logic [BaseW-1:0] lookup_address;

  modport source (
    output valid, mode, base_address, region_size, build_dirty, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, mode, base_address, region_size, build_dirty, lookup_address,
    output ready
  );
endinterface

>>> rtl/arat_rsp_if.sv
interface arat_rsp_if import arat_pkg::*;;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   slot_index;
  logic [OffW-1:0]    offset;
  logic               hit_dirty;
  logic               hit_unloaded;

  modport source (
    output valid, status, slot_index, offset, hit_dirty, hit_unloaded,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, offset, hit_dirty, hit_unloaded,
    output ready
  );
endinterface

>>> rtl/arat_ram.sv
module arat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/address_range_region_table.sv
// Address range region table.
// Request channel req_i carries one operation per beat: add a region, mark all
// regions with a given base as unloaded, or look up an address. Response
// channel rsp_o returns exactly one beat per request, in order.
// Regions live in one registered-read RAM, one entry per slot. Slots fill from
// zero upward and are never freed, so a fill counter stands in for used bits.
// Add and the unused mode code go from accept to the done state, then to the
// response register. Mark walks every used slot through the single read port
// and writes the hit slots back. Lookup walks the same way and stops at the
// first covering slot, or reports a miss after the last used slot. The scan
// reads one slot per cycle over the RAM read port, and the request side stays
// closed while the scan runs.
// A new request is taken once the previous one has reached the response
// register, while that response beat may still wait for rsp_o.ready.
// A stalled receiver holds the response; a finished next result then waits in
// its own register and the request side stays closed.
// Reset empties the table at once (fill count to zero); no clearing pass.
module address_range_region_table_core import arat_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef,
  parameter int unsigned AddrBits     = AddrBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arat_req_if.sink   req_i,
  arat_rsp_if.source rsp_o
);

  localparam int unsigned Iw = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned Cw = $clog2(TableEntries + 1);
  localparam int unsigned Ew = AddrBits + SizeW + 2;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [AddrBits-1:0] base_q, base_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [Cw-1:0]       fill_q, fill_d;
  logic [Cw-1:0]       idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [Iw-1:0]       rd_idx_q, rd_idx_d;

  status_e             res_status_q, res_status_d;
  logic [SlotW-1:0]    res_slot_q, res_slot_d;
  logic [OffW-1:0]     res_off_q, res_off_d;
  logic                res_dirty_q, res_dirty_d;
  logic                res_unl_q, res_unl_d;

  logic                out_vld_q, out_vld_d;
  status_e             out_status_q, out_status_d;
  logic [SlotW-1:0]    out_slot_q, out_slot_d;
  logic [OffW-1:0]     out_off_q, out_off_d;
  logic                out_dirty_q, out_dirty_d;
  logic                out_unl_q, out_unl_d;

  logic                accept;
  logic                ram_we, ram_re;
  logic [Iw-1:0]       ram_waddr, ram_raddr;
  logic [Ew-1:0]       ram_wdata, ram_rdata;

  logic [AddrBits-1:0] ent_base;
  logic [SizeW-1:0]    ent_size;
  logic                ent_dirty, ent_unl;
  logic [AddrBits-1:0] diff;
  logic                covers, base_hit, more;

  arat_ram #(
    .Width (Ew),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_base  = ram_rdata[Ew-1 -: AddrBits];
  assign ent_size  = ram_rdata[SizeW+1:2];
  assign ent_dirty = ram_rdata[1];
  assign ent_unl   = ram_rdata[0];

  assign diff     = addr_q - ent_base;
  assign covers   = (addr_q >= ent_base) && (diff < AddrBits'(ent_size));
  assign base_hit = (ent_base == base_q);
  assign more     = (idx_q < fill_q);

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot_index   = out_slot_q;
  assign rsp_o.offset       = out_off_q;
  assign rsp_o.hit_dirty    = out_dirty_q;
  assign rsp_o.hit_unloaded = out_unl_q;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    base_d       = base_q;
    addr_d       = addr_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_off_d    = res_off_q;
    res_dirty_d  = res_dirty_q;
    res_unl_d    = res_unl_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_off_d    = out_off_q;
    out_dirty_d  = out_dirty_q;
    out_unl_d    = out_unl_q;
    ram_we       = 1'b0;
    ram_waddr    = fill_q[Iw-1:0];
    ram_wdata    = {req_i.base_address[AddrBits-1:0], req_i.region_size,
                    req_i.build_dirty, 1'b0};
    ram_re       = 1'b0;
    ram_raddr    = idx_q[Iw-1:0];

    // drop the response beat once taken
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          mode_d       = mode_e'(req_i.mode);
          base_d       = req_i.base_address[AddrBits-1:0];
          addr_d       = req_i.lookup_address[AddrBits-1:0];
          idx_d        = '0;
          res_status_d = StatusOk;
          res_slot_d   = '0;
          res_off_d    = '0;
          res_dirty_d  = 1'b0;
          res_unl_d    = 1'b0;
          case (mode_e'(req_i.mode))
            ModeAdd: begin
              if (fill_q != Cw'(TableEntries)) begin
                ram_we     = 1'b1;
                fill_d     = fill_q + Cw'(1);
                res_slot_d = SlotW'(fill_q);
              end else begin
                res_status_d = StatusFull;
              end
              state_d = StDone;
            end
            ModeMark: begin
              state_d = StScan;
            end
            ModeLookup: begin
              res_status_d = StatusMiss;
              state_d      = StScan;
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end
      StScan: begin
        ram_re = more;
        if (rd_vld_q) begin
          if (mode_q == ModeMark) begin
            if (base_hit) begin
              // write back the entry with its unloaded mark set
              ram_we    = 1'b1;
              ram_waddr = rd_idx_q;
              ram_wdata = {ram_rdata[Ew-1:1], 1'b1};
            end
          end else if (covers) begin
            ram_re       = 1'b0;
            res_status_d = StatusOk;
            res_slot_d   = SlotW'(rd_idx_q);
            res_off_d    = diff[OffW-1:0];
            res_dirty_d  = ent_dirty;
            res_unl_d    = ent_unl;
            state_d      = StDone;
          end
        end
        if (ram_re) begin
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[Iw-1:0];
          idx_d    = idx_q + Cw'(1);
        end else if (!rd_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_off_d    = res_off_q;
          out_dirty_d  = res_dirty_q;
          out_unl_d    = res_unl_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    base_q       <= base_d;
    addr_q       <= addr_d;
    idx_q        <= idx_d;
    rd_idx_q     <= rd_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_off_q    <= res_off_d;
    res_dirty_q  <= res_dirty_d;
    res_unl_q    <= res_unl_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_off_q    <= out_off_d;
    out_dirty_q  <= out_dirty_d;
    out_unl_q    <= out_unl_d;
  end

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Cw'(TableEntries))
    else $error("fill count beyond table depth");

  a_read_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (Cw'(rd_idx_q) < fill_q))
    else $error("scan read an unused slot");

  a_scan_write_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == StScan) |-> (mode_q == ModeMark && rd_vld_q))
    else $error("table write during scan outside mark");

  a_add_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.mode == ModeAdd && fill_q != Cw'(TableEntries))
      |=> (fill_q == $past(fill_q) + Cw'(1)))
    else $error("add did not advance fill count");

  a_done_one_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && state_d == StIdle) |=> out_vld_q)
    else $error("finished item left no response beat");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import arat_pkg::*;

  localparam int unsigned Slots         = TableEntriesDef;
  localparam int unsigned CycleLimit    = 1_500_000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned HoldoffCycles = 300;

  localparam logic [ModeW-1:0] ModeUnused  = 2'd3;
  localparam logic [BaseW-1:0] AddrMax     = '1;
  localparam logic [SizeW-1:0] SizeMax     = '1;
  localparam logic [BaseW-1:0] ClusterBase = 64'h0000_0000_1000_0000;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [BaseW-1:0] base;
    logic [SizeW-1:0] size;
    logic             dirty;
    logic [BaseW-1:0] addr;
  } region_op_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [OffW-1:0]    offset;
    logic               dirty;
    logic               unloaded;
  } region_rsp_t;

  logic clk_i;
  logic rst_ni;

  arat_req_if req_if ();
  arat_rsp_if rsp_if ();

  address_range_region_table_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Table image kept alongside the block
  bit             tbl_used     [Slots];
  bit [BaseW-1:0] tbl_base     [Slots];
  bit [SizeW-1:0] tbl_size     [Slots];
  bit             tbl_dirty    [Slots];
  bit             tbl_unloaded [Slots];
  int unsigned    tbl_fill = 0;

  region_rsp_t expected_rsp_q [$];
  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;
  int unsigned holdoff_requested = 0;
  bit          send_gaps_on      = 1'b1;
  bit          rsp_stalls_on     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic region_rsp_t predict_region_op(region_op_t op);
    region_rsp_t    rsp;
    bit [BaseW-1:0] delta;
    rsp = '{status: StatusOk, slot: '0, offset: '0, dirty: 1'b0, unloaded: 1'b0};
    case (op.mode)
      ModeAdd: begin
        rsp.status = StatusFull;
        for (int s = 0; s < Slots; s++) begin
          if (!tbl_used[s]) begin
            tbl_used[s]     = 1'b1;
            tbl_base[s]     = op.base;
            tbl_size[s]     = op.size;
            tbl_dirty[s]    = op.dirty;
            tbl_unloaded[s] = 1'b0;
            tbl_fill++;
            rsp.status = StatusOk;
            rsp.slot   = SlotW'(s);
            break;
          end
        end
      end
      ModeMark: begin
        for (int s = 0; s < Slots; s++)
          if (tbl_used[s] && tbl_base[s] == op.base) tbl_unloaded[s] = 1'b1;
      end
      ModeLookup: begin
        rsp.status = StatusMiss;
        for (int s = 0; s < Slots; s++) begin
          delta = op.addr - tbl_base[s];
          if (tbl_used[s] && op.addr >= tbl_base[s] && delta < BaseW'(tbl_size[s])) begin
            rsp.status   = StatusOk;
            rsp.slot     = SlotW'(s);
            rsp.offset   = delta[OffW-1:0];
            rsp.dirty    = tbl_dirty[s];
            rsp.unloaded = tbl_unloaded[s];
            break;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic region_op_t make_op(logic [ModeW-1:0] mode, logic [BaseW-1:0] base,
                                         logic [SizeW-1:0] size, logic dirty,
                                         logic [BaseW-1:0] addr);
    region_op_t op;
    op.mode  = mode;
    op.base  = base;
    op.size  = size;
    op.dirty = dirty;
    op.addr  = addr;
    return op;
  endfunction

  function automatic int unsigned pick_gap(bit enabled);
    int unsigned roll;
    roll = $urandom_range(99);
    if (!enabled || roll < 55) return 0;
    if (roll < 93) return $urandom_range(4, 1);
    return $urandom_range(90, 12);
  endfunction

  function automatic logic [BaseW-1:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [BaseW-1:0] pick_base();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return rand_addr();
    if (roll < 65) return ClusterBase + BaseW'($urandom_range(16'hFFFF, 0));
    if (roll < 80 && tbl_fill != 0) return tbl_base[$urandom_range(tbl_fill - 1, 0)];
    // near the top of the address space
    return ~BaseW'($urandom());
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 15) return SizeW'(1);
    if (roll < 55) return SizeW'($urandom_range(4096, 1));
    if (roll < 65) return SizeMax;
    return $urandom();
  endfunction

  function automatic logic [BaseW-1:0] pick_mark_base();
    if (tbl_fill != 0 && $urandom_range(99) < 60)
      return tbl_base[$urandom_range(tbl_fill - 1, 0)];
    return pick_base();
  endfunction

  function automatic logic [BaseW-1:0] pick_lookup_addr();
    int unsigned    roll;
    int unsigned    s;
    bit [BaseW-1:0] b;
    bit [SizeW-1:0] sz;
    roll = $urandom_range(99);
    if (tbl_fill != 0 && roll < 75) begin
      s  = $urandom_range(tbl_fill - 1, 0);
      b  = tbl_base[s];
      sz = tbl_size[s];
      if (roll < 55 && sz != 0) return b + BaseW'($urandom() % sz);
      // region boundaries
      case ($urandom_range(3, 0))
        0:       return b;
        1:       return b - 1;
        2:       return b + BaseW'(sz);
        default: return b + BaseW'(sz) - 1;
      endcase
    end
    if (roll < 88) return ClusterBase + BaseW'($urandom_range(20'hFFFFF, 0));
    return rand_addr();
  endfunction

  function automatic region_op_t random_region_op(int unsigned fill_cap);
    region_op_t  op;
    int unsigned roll;
    roll = $urandom_range(99);
    // fields the operation ignores still carry noise
    op = make_op(ModeUnused, rand_addr(), $urandom(), 1'($urandom()), rand_addr());
    if (roll < 14 && tbl_fill < fill_cap) begin
      op.mode = ModeAdd;
      op.base = pick_base();
      op.size = pick_size();
    end else if (roll < 25) begin
      op.mode = ModeMark;
      op.base = pick_mark_base();
    end else if (roll < 96) begin
      op.mode = ModeLookup;
      op.addr = pick_lookup_addr();
    end
    return op;
  endfunction

  task automatic send_region_op(input region_op_t op);
    int unsigned gap;
    gap = pick_gap(send_gaps_on);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.mode           <= op.mode;
    req_if.base_address   <= op.base;
    req_if.region_size    <= op.size;
    req_if.build_dirty    <= op.dirty;
    req_if.lookup_address <= op.addr;
    do begin
      @(posedge clk_i);
    end while (req_if.ready !== 1'b1);
    expected_rsp_q.push_back(predict_region_op(op));
  endtask

  task automatic test_directed_edges();
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, AddrMax));
    send_region_op(make_op(ModeMark, '0, '0, 1'b0, '0));
    send_region_op(make_op(ModeUnused, AddrMax, SizeMax, 1'b1, AddrMax));
    // zero size region never covers anything
    send_region_op(make_op(ModeAdd, '0, '0, 1'b1, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, '0));
    send_region_op(make_op(ModeAdd, 64'h1000, 32'h100, 1'b0, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h1000));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h10FF));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h1100));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h0FFF));
    // overlap: the lowest slot wins
    send_region_op(make_op(ModeAdd, 64'h1080, 32'h1000, 1'b1, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h10C0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h1100));
    // duplicate base, mark hits both
    send_region_op(make_op(ModeAdd, 64'h1000, 32'h10, 1'b1, '0));
    send_region_op(make_op(ModeMark, 64'h1000, '0, 1'b0, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'h1005));
    send_region_op(make_op(ModeMark, 64'h5555, '0, 1'b0, '0));
    send_region_op(make_op(ModeAdd, AddrMax, SizeMax, 1'b1, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, AddrMax));
    send_region_op(make_op(ModeAdd, 64'hFFFF_FFFF_0000_0000, SizeMax, 1'b0, '0));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE));
    send_region_op(make_op(ModeLookup, AddrMax, SizeMax, 1'b1, 64'hFFFF_FFFF_0000_0000));
  endtask

  task automatic test_backpressure();
    // hold the response side while requests keep coming back to back
    send_gaps_on = 1'b0;
    holdoff_requested++;
    repeat (16) send_region_op(random_region_op(100));
    send_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned fill_cap);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        send_gaps_on  = ($urandom_range(3, 0) != 0);
        rsp_stalls_on = ($urandom_range(3, 0) != 0);
      end
      send_region_op(random_region_op(fill_cap));
    end
    send_gaps_on  = 1'b1;
    rsp_stalls_on = 1'b1;
  endtask

  task automatic test_fill_to_capacity();
    while (tbl_fill < Slots) begin
      send_region_op(make_op(ModeAdd, pick_base(), pick_size(), 1'($urandom()), rand_addr()));
      if ($urandom_range(1, 0) != 0)
        send_region_op(make_op(ModeLookup, rand_addr(), $urandom(), 1'b0, pick_lookup_addr()));
    end
    // table full from here on
    repeat (6) send_region_op(make_op(ModeAdd, pick_base(), pick_size(), 1'b1, rand_addr()));
    send_region_op(make_op(ModeLookup, '0, '0, 1'b0, pick_lookup_addr()));
  endtask

  initial begin : rsp_ready_driver
    int unsigned stall_left;
    int unsigned holdoff_served;
    int unsigned roll;
    stall_left     = 0;
    holdoff_served = 0;
    rsp_if.ready   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_served != holdoff_requested) begin
        holdoff_served = holdoff_requested;
        stall_left     = HoldoffCycles;
      end else if (stall_left == 0 && rsp_stalls_on) begin
        roll = $urandom_range(99);
        if (roll < 15) stall_left = $urandom_range(3, 1);
        else if (roll < 17) stall_left = $urandom_range(80, 15);
      end
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : rsp_checker
    region_rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: response beat with nothing pending: status %0d slot %0d",
                   $realtime, rsp_if.status, rsp_if.slot_index);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_if.status !== want.status || rsp_if.slot_index !== want.slot ||
            rsp_if.offset !== want.offset || rsp_if.hit_dirty !== want.dirty ||
            rsp_if.hit_unloaded !== want.unloaded) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: mismatch: expected status %0d slot %0d offset %h dirty %b unloaded %b",
                     $realtime, want.status, want.slot, want.offset, want.dirty,
                     want.unloaded);
            $display("%0t: mismatch: got status %0d slot %0d offset %h dirty %b unloaded %b",
                     $realtime, rsp_if.status, rsp_if.slot_index, rsp_if.offset,
                     rsp_if.hit_dirty, rsp_if.hit_unloaded);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.mode           = ModeAdd;
    req_if.base_address   = '0;
    req_if.region_size    = '0;
    req_if.build_dirty    = 1'b0;
    req_if.lookup_address = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_backpressure();
    test_random_traffic(520, 100);
    test_fill_to_capacity();
    test_random_traffic(250, Slots);

    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    // let any stray beat show up
    repeat (Slots + 8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/arat_pkg.sv
rtl/arat_req_if.sv
rtl/arat_rsp_if.sv
rtl/arat_ram.sv
rtl/address_range_region_table.sv
bench/testbench.sv
